[hdl/ip_to_mac_neighbor_cache_unit_assert.svh]
// ----------------------------------------------------------------------------
// Neighbor cache assertion macros
// Clocked assertion shorthands used by the neighbor cache top module.
// ----------------------------------------------------------------------------
`ifndef IP_TO_MAC_NEIGHBOR_CACHE_UNIT_ASSERT_SVH
`define IP_TO_MAC_NEIGHBOR_CACHE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define NCU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define NCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define NCU_ASSERT_SAME(lbl, ante, cons, msg)

`define NCU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hdl/ncu_pkg.sv]
// ----------------------------------------------------------------------------
// Neighbor cache package
// Sizes, codes and word types shared by the neighbor cache modules.
// ----------------------------------------------------------------------------
package ncu_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	localparam logic [31:0] BCAST_IP = 32'hffff_ffff;
	localparam logic [47:0] BCAST_MAC = 48'hffff_ffff_ffff;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_REMEMBER = 1'b1;

	typedef enum logic [1:0] {
		ACT_LOOKUP,
		ACT_IGNORED,
		ACT_UPDATE,
		ACT_INSERT
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic operation;
		logic [31:0] ip_addr;
		logic [47:0] mac_addr;
	} ncu_in_t;

	typedef struct packed {
		logic found;
		logic [47:0] mac_out;
		action_t action;
	} ncu_out_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} tbl_entry_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] addr;
		tbl_entry_t data;
	} tbl_wr_t;

endpackage

[hdl/ncu_table.sv]
// ----------------------------------------------------------------------------
// Neighbor cache table
// Pair memory with one read and one write port, registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module ncu_table import ncu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [IDX_W-1:0] rd_addr,
	output tbl_entry_t rd_data,
	input tbl_wr_t wr
);

	tbl_entry_t mem_q [TABLE_ENTRIES];
	tbl_entry_t rd_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// An entry never written reads as the cleared pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

[hdl/ip_to_mac_neighbor_cache_unit.sv]
// ----------------------------------------------------------------------------
// IPv4 to MAC neighbor cache
// Resolves IPv4 addresses to MAC addresses and learns new pairs.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The table memory has a
// single read port, so the search reads one entry per cycle across all 16
// entries; state ST_LAST then compares the last entry and state ST_FINISH
// writes back and registers the result. The result appears for exactly one
// cycle with done high and must be taken then, since it cannot be held off. A
// new word may be started in the same cycle as done.
module ip_to_mac_neighbor_cache_unit import ncu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ncu_in_t cmd,
	output logic done,
	output ncu_out_t result
);

`include "ip_to_mac_neighbor_cache_unit_assert.svh"

	state_t state_q, state_d;
	ncu_in_t cmd_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] head_q;
	logic chk_s1;
	logic [IDX_W-1:0] slot_s1;
	logic hit_q;
	logic [IDX_W-1:0] hit_slot_q;
	logic [47:0] hit_mac_q;
	logic done_q;
	ncu_out_t result_q, res_d;
	logic rd_en;
	tbl_entry_t rd_data;
	tbl_wr_t tbl_wr;

	ncu_table u_table (
		.clk (clk),
		.arst_n (arst_n),
		.rd_en (rd_en),
		.rd_addr (cnt_q),
		.rd_data (rd_data),
		.wr (tbl_wr)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == IDX_W'(TABLE_ENTRIES - 1)) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en = (state_q == ST_SCAN);
		res_d = '0;
		res_d.action = ACT_LOOKUP;
		tbl_wr = '0;
		if (state_q == ST_FINISH) begin
			if (cmd_q.operation == OP_LOOKUP) begin
				priority if (cmd_q.ip_addr == BCAST_IP) begin
					res_d.found = 1'b1;
					res_d.mac_out = BCAST_MAC;
				end else if (cmd_q.ip_addr != '0 && hit_q) begin
					res_d.found = 1'b1;
					res_d.mac_out = hit_mac_q;
				end else begin
					res_d.found = 1'b0;
				end
			end else begin
				priority if (cmd_q.ip_addr == '0 || cmd_q.ip_addr == BCAST_IP) begin
					res_d.action = ACT_IGNORED;
				end else if (hit_q) begin
					res_d.action = ACT_UPDATE;
					tbl_wr.en = 1'b1;
					tbl_wr.addr = hit_slot_q;
					tbl_wr.data = '{ip: cmd_q.ip_addr, mac: cmd_q.mac_addr};
				end else begin
					res_d.action = ACT_INSERT;
					tbl_wr.en = 1'b1;
					tbl_wr.addr = head_q;
					tbl_wr.data = '{ip: cmd_q.ip_addr, mac: cmd_q.mac_addr};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			head_q <= '0;
			chk_s1 <= 1'b0;
			hit_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1 <= rd_en;
			done_q <= (state_q == ST_FINISH);
			if (state_q == ST_IDLE && start) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (chk_s1 && !hit_q && rd_data.ip == cmd_q.ip_addr) begin
				hit_q <= 1'b1;
			end
			if (state_q == ST_FINISH && res_d.action == ACT_INSERT) begin
				head_q <= (head_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : head_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		slot_s1 <= cnt_q;
		if (chk_s1 && !hit_q && rd_data.ip == cmd_q.ip_addr) begin
			hit_slot_q <= slot_s1;
			hit_mac_q <= rd_data.mac;
		end
		if (state_q == ST_FINISH) begin
			result_q <= res_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = result_q;

	`NCU_ASSERT_SAME(a_done_after_finish, done_q, $past(state_q == ST_FINISH), "Result strobe without a finished search.")
	`NCU_ASSERT_SAME(a_head_on_insert, head_q != $past(head_q), $past(state_q == ST_FINISH && res_d.action == ACT_INSERT), "Insert head moved without an insert.")
	`NCU_ASSERT_NEXT(a_write_reported, tbl_wr.en, done_q && (result_q.action == ACT_UPDATE || result_q.action == ACT_INSERT), "Table write not reported as update or insert.")
	`NCU_ASSERT_SAME(a_found_lookup, done_q && result_q.found, result_q.action == ACT_LOOKUP, "Found set on a remember word.")

endmodule

[tb/sv/ip_to_mac_neighbor_cache_unit_tb.sv]
// ----------------------------------------------------------------------------
// Neighbor cache testbench
// Sends lookup and remember words to the neighbor cache, keeps its own copy
// of the address table to work out each answer, and checks every result
// field by field in arrival order. A short directed run covers the empty
// table, broadcast, zero addresses and in-place updates. A long random run
// then draws most addresses from a small changing pool so that hits,
// updates, evictions and head wraps happen often.
// ----------------------------------------------------------------------------
module ip_to_mac_neighbor_cache_unit_tb;
	import ncu_pkg::*;

	localparam int RANDOM_WORDS = 1700;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int POOL_MAX = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	ncu_in_t cmd = '0;
	logic done;
	ncu_out_t result;

	ncu_in_t pending_words[$];
	ncu_out_t answers_due[$];
	logic [31:0] cache_ip[TABLE_ENTRIES];
	logic [47:0] cache_mac[TABLE_ENTRIES];
	logic [IDX_W-1:0] cache_head = '0;
	logic [31:0] ip_pool[POOL_MAX];
	int pool_len;
	int total_words;
	int words_taken = 0;
	int mismatch_count = 0;
	int cycle_count;

	ip_to_mac_neighbor_cache_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [47:0] random_mac();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[47:0];
	endfunction

	function automatic logic [31:0] random_unicast_ip();
		logic [31:0] ip;
		ip = $urandom;
		while (ip == '0 || ip == BCAST_IP) ip = $urandom;
		return ip;
	endfunction

	function automatic ncu_in_t make_word(logic op, logic [31:0] ip, logic [47:0] mac);
		ncu_in_t w;
		w.operation = op;
		w.ip_addr = ip;
		w.mac_addr = mac;
		return w;
	endfunction

	function automatic ncu_out_t resolve_word(ncu_in_t w);
		ncu_out_t r;
		int slot;
		r = '0;
		r.action = ACT_LOOKUP;
		slot = -1;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			if (slot < 0 && cache_ip[k] == w.ip_addr) slot = k;
		end
		if (w.operation == OP_LOOKUP) begin
			if (w.ip_addr == BCAST_IP) begin
				r.found = 1'b1;
				r.mac_out = BCAST_MAC;
			end else if (w.ip_addr != '0 && slot >= 0) begin
				r.found = 1'b1;
				r.mac_out = cache_mac[slot];
			end
		end else if (w.ip_addr == '0 || w.ip_addr == BCAST_IP) begin
			r.action = ACT_IGNORED;
		end else if (slot >= 0) begin
			cache_mac[slot] = w.mac_addr;
			r.action = ACT_UPDATE;
		end else begin
			cache_ip[cache_head] = w.ip_addr;
			cache_mac[cache_head] = w.mac_addr;
			cache_head = (int'(cache_head) == TABLE_ENTRIES - 1) ? '0 : cache_head + 1'b1;
			r.action = ACT_INSERT;
		end
		return r;
	endfunction

	function automatic int idle_percent();
		if (words_taken < total_words / 3) return 10;
		if (words_taken < (2 * total_words) / 3) return 74;
		return 0;
	endfunction

	always @(posedge clk) begin : drive_blk
		logic took;
		took = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				took = 1'b1;
				answers_due.push_back(resolve_word(cmd));
				void'(pending_words.pop_front());
				words_taken++;
			end
			if (!start || took) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= idle_percent()) begin
					start <= 1'b1;
					cmd <= pending_words[0];
				end else begin
					start <= 1'b0;
					cmd <= make_word(1'($urandom_range(1)), $urandom, random_mac());
				end
			end
		end
	end

	always @(posedge clk) begin : check_blk
		ncu_out_t want;
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				$display("%0t: result with none due, expected nothing actual %h", $time, result);
				mismatch_count++;
			end else begin
				want = answers_due.pop_front();
				if (result.found !== want.found) begin
					$display("%0t: found expected %0d actual %0d", $time, want.found,
						result.found);
					mismatch_count++;
				end
				if (result.mac_out !== want.mac_out) begin
					$display("%0t: mac_out expected %h actual %h", $time, want.mac_out,
						result.mac_out);
					mismatch_count++;
				end
				if (result.action !== want.action) begin
					$display("%0t: action expected %0d actual %0d", $time, want.action,
						result.action);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stim_blk
		int pick;
		logic [31:0] ip;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			cache_ip[k] = '0;
			cache_mac[k] = '0;
		end

		// Empty table: zero address, broadcast and a plain miss; then ignored, new and updated pairs.
		pending_words.push_back(make_word(OP_LOOKUP, 32'h0, random_mac()));
		pending_words.push_back(make_word(OP_LOOKUP, BCAST_IP, random_mac()));
		pending_words.push_back(make_word(OP_LOOKUP, 32'h0000_0001, 48'h0));
		pending_words.push_back(make_word(OP_REMEMBER, 32'h0, BCAST_MAC));
		pending_words.push_back(make_word(OP_REMEMBER, BCAST_IP, BCAST_MAC));
		pending_words.push_back(make_word(OP_REMEMBER, 32'hffff_fffe, BCAST_MAC));
		pending_words.push_back(make_word(OP_REMEMBER, 32'h0000_0001, 48'h0));
		pending_words.push_back(make_word(OP_LOOKUP, 32'h0000_0001, BCAST_MAC));
		pending_words.push_back(make_word(OP_LOOKUP, 32'hffff_fffe, 48'h0));
		pending_words.push_back(make_word(OP_LOOKUP, 32'h0, 48'h0));
		pending_words.push_back(make_word(OP_REMEMBER, 32'hffff_fffe, 48'h8000_0000_0001));
		pending_words.push_back(make_word(OP_LOOKUP, 32'hffff_fffe, 48'h0));
		pending_words.push_back(make_word(OP_REMEMBER, 32'h8000_0000, 48'h8000_0000_0000));
		pending_words.push_back(make_word(OP_REMEMBER, 32'h7fff_ffff, 48'h7fff_ffff_ffff));
		pending_words.push_back(make_word(OP_LOOKUP, 32'h8000_0000, 48'h0));
		pending_words.push_back(make_word(OP_LOOKUP, 32'h7fff_ffff, 48'h0));
		pending_words.push_back(make_word(OP_REMEMBER, 32'h0000_0001, BCAST_MAC));
		pending_words.push_back(make_word(OP_LOOKUP, 32'h0000_0001, 48'h0));
		pending_words.push_back(make_word(OP_LOOKUP, BCAST_IP, 48'h0));

		pool_len = 4;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 100 == 0) begin
				pool_len = $urandom_range(POOL_MAX, 4);
				for (int k = 0; k < POOL_MAX; k++) begin
					if (n == 0 || $urandom_range(3) == 0) ip_pool[k] = random_unicast_ip();
				end
			end
			ip = ip_pool[$urandom_range(pool_len - 1)];
			pick = $urandom_range(99);
			if (pick < 40) begin
				pending_words.push_back(make_word(OP_LOOKUP, ip, random_mac()));
			end else if (pick < 78) begin
				pending_words.push_back(make_word(OP_REMEMBER, ip, random_mac()));
			end else if (pick < 88) begin
				pending_words.push_back(make_word(OP_LOOKUP, $urandom, random_mac()));
			end else if (pick < 93) begin
				pending_words.push_back(make_word(OP_REMEMBER, $urandom, random_mac()));
			end else begin
				pending_words.push_back(make_word(1'($urandom_range(1)),
					($urandom_range(1) == 1) ? BCAST_IP : 32'h0, random_mac()));
			end
		end
		total_words = pending_words.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken < total_words) @(posedge clk);
		while (answers_due.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/ncu_pkg.sv
hdl/ncu_table.sv
hdl/ip_to_mac_neighbor_cache_unit.sv
tb/sv/ip_to_mac_neighbor_cache_unit_tb.sv
